// ----- rtl/poi_pkg.sv -----
package poi_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int POSITION_BITS_DEF     = 32;

  // CORDIC arctangent table depth and seed.
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IW    = 5;
  localparam logic signed [31:0] INV_GAIN_Q30    = 32'sd652032874;
  // 2^16 / (2*pi), Q.16
  localparam logic signed [31:0] RAD_TO_TURN_Q16 = 32'sd683565276;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_QUAD,
    ST_MUL_PX,
    ST_MUL_PY,
    ST_MUL_PW,
    ST_MUL_XC,
    ST_MUL_YS,
    ST_MUL_XS,
    ST_MUL_YC,
    ST_MUL_HD,
    ST_POS,
    ST_DONE
  } poi_state_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [31:0] atan_turn(input logic [ATAN_IW-1:0] i);
    logic signed [31:0] v;
    unique case (i)
      5'd0:    v = 32'sd536870912;
      5'd1:    v = 32'sd316933406;
      5'd2:    v = 32'sd167458907;
      5'd3:    v = 32'sd85004756;
      5'd4:    v = 32'sd42667331;
      5'd5:    v = 32'sd21354465;
      5'd6:    v = 32'sd10679838;
      5'd7:    v = 32'sd5340245;
      5'd8:    v = 32'sd2670163;
      5'd9:    v = 32'sd1335087;
      5'd10:   v = 32'sd667544;
      5'd11:   v = 32'sd333772;
      5'd12:   v = 32'sd166886;
      5'd13:   v = 32'sd83443;
      5'd14:   v = 32'sd41721;
      5'd15:   v = 32'sd20860;
      5'd16:   v = 32'sd10430;
      5'd17:   v = 32'sd5215;
      5'd18:   v = 32'sd2607;
      5'd19:   v = 32'sd1303;
      5'd20:   v = 32'sd651;
      5'd21:   v = 32'sd325;
      5'd22:   v = 32'sd162;
      5'd23:   v = 32'sd81;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/poi_item_if.sv -----
interface poi_item_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] lin_vel_x;
  logic signed [15:0] lin_vel_y;
  logic signed [15:0] ang_vel;
  logic        [15:0] time_step;

  modport source (output valid, lin_vel_x, lin_vel_y, ang_vel, time_step, input ready);
  modport sink   (input valid, lin_vel_x, lin_vel_y, ang_vel, time_step, output ready);
endinterface

// ----- rtl/poi_result_if.sv -----
interface poi_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [15:0] heading;
  logic               saturated;

  modport source (output valid, pos_x, pos_y, heading, saturated, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, saturated, output ready);
endinterface

// ----- rtl/planar_odometry_integrator_core.sv -----
// Planar dead-reckoning integrator. Each item transfer on "item" brings body
// velocities (Q4.12), a yaw rate (Q4.12 rad/s) and a time step (Q0.16 s); one
// result follows on "result" with the new world position (Q16.16, low 32 bits
// of the stored POSITION_BITS coordinate), the new binary-angle heading and a
// flag that is set when either coordinate clipped at its limit. The heading
// used for the rotation is the one held before the step. A result follows
// its item transfer through the CORDIC_ITERATIONS micro-rotations, the
// quarter-turn fold, eight passes through the single shared 32x32 signed
// multiplier, the position/heading update and the load of the result
// register. The input is ready again from the same clock edge that loads
// the result register, so a new item is not taken before the last one is
// through, but the next item can start while the previous result still
// waits to be taken. An item that finishes while the result register is
// still full holds in its last state, with the input not ready, until the
// result transfers. Reset clears the pose and heading to zero.
module planar_odometry_integrator_core
  import poi_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
  parameter int POSITION_BITS     = POSITION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  poi_item_if.sink      item,
  poi_result_if.source  result
);

  localparam int CW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
  localparam int PB = POSITION_BITS;

  poi_state_t state, state_next;

  logic [CW-1:0] iter;

  // Latched input item.
  logic signed [15:0] vx, vy, w;
  logic        [15:0] dt;

  // CORDIC working registers, Q2.30 and 2^-32 turn.
  logic signed [31:0] cx, cy, z;
  logic        [1:0]  quad;

  // Multiplier pipeline registers.
  logic signed [31:0] px, py, pw;
  logic signed [63:0] prod, acc, accx, accy;

  // Pose state.
  logic signed [PB-1:0] pose_x, pose_y;
  logic        [15:0]   yaw;
  logic                 clip;

  // Result register.
  logic               res_valid;
  logic signed [31:0] res_x, res_y;
  logic        [15:0] res_hdg;
  logic               res_sat;

  // Shared multiplier.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Heading split into quadrant and residual.
  logic [15:0]        yaw_bias;
  logic [15:0]        yaw_res;
  assign yaw_bias = yaw + 16'h2000;
  assign yaw_res  = yaw - {yaw_bias[15:14], 14'd0};

  // One CORDIC micro-rotation.
  logic signed [31:0] sh_x, sh_y, atan_v;
  assign sh_x   = cy >>> iter;
  assign sh_y   = cx >>> iter;
  assign atan_v = atan_turn(ATAN_IW'(iter));

  // Position update: round to 16 fraction bits, add, saturate.
  logic signed [63:0] rnd_x, rnd_y;
  logic signed [21:0] dx, dy;
  logic signed [PB:0] sum_x, sum_y;
  logic               ovf_x, ovf_y;
  logic signed [PB-1:0] pose_x_next, pose_y_next;
  localparam logic signed [PB-1:0] POS_MAX = {1'b0, {(PB-1){1'b1}}};
  localparam logic signed [PB-1:0] POS_MIN = {1'b1, {(PB-1){1'b0}}};

  assign rnd_x = accx + (64'sd1 <<< 41);
  assign rnd_y = accy + (64'sd1 <<< 41);
  assign dx    = rnd_x[63:42];
  assign dy    = rnd_y[63:42];
  assign sum_x = (PB+1)'(pose_x) + (PB+1)'(dx);
  assign sum_y = (PB+1)'(pose_y) + (PB+1)'(dy);
  assign ovf_x = sum_x[PB] != sum_x[PB-1];
  assign ovf_y = sum_y[PB] != sum_y[PB-1];

  always_comb begin
    pose_x_next = sum_x[PB-1:0];
    if (ovf_x) begin
      pose_x_next = sum_x[PB] ? POS_MIN : POS_MAX;
    end
    pose_y_next = sum_y[PB-1:0];
    if (ovf_y) begin
      pose_y_next = sum_y[PB] ? POS_MIN : POS_MAX;
    end
  end

  // Heading update: round half away from zero, keep 16 bits.
  logic        [63:0] hd_mag, hd_rnd;
  logic        [15:0] hd_step, yaw_next;
  assign hd_mag   = prod[63] ? 64'(-prod) : 64'(prod);
  assign hd_rnd   = hd_mag + (64'd1 << 43);
  assign hd_step  = prod[63] ? 16'(-hd_rnd[59:44]) : hd_rnd[59:44];
  assign yaw_next = yaw + hd_step;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (item.valid) state_next = ST_ROTATE;
      ST_ROTATE: if (iter == CW'(CORDIC_ITERATIONS - 1)) state_next = ST_QUAD;
      ST_QUAD:   state_next = ST_MUL_PX;
      ST_MUL_PX: state_next = ST_MUL_PY;
      ST_MUL_PY: state_next = ST_MUL_PW;
      ST_MUL_PW: state_next = ST_MUL_XC;
      ST_MUL_XC: state_next = ST_MUL_YS;
      ST_MUL_YS: state_next = ST_MUL_XS;
      ST_MUL_XS: state_next = ST_MUL_YC;
      ST_MUL_YC: state_next = ST_MUL_HD;
      ST_MUL_HD: state_next = ST_POS;
      ST_POS:    state_next = ST_DONE;
      ST_DONE:   if (!res_valid || result.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Multiplier operand select and handshake outputs.
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    unique case (state)
      ST_MUL_PX: begin mul_a = 32'(vx); mul_b = {16'd0, dt}; end
      ST_MUL_PY: begin mul_a = 32'(vy); mul_b = {16'd0, dt}; end
      ST_MUL_PW: begin mul_a = 32'(w);  mul_b = {16'd0, dt}; end
      ST_MUL_XC: begin mul_a = px; mul_b = cx; end
      ST_MUL_YS: begin mul_a = py; mul_b = cy; end
      ST_MUL_XS: begin mul_a = px; mul_b = cy; end
      ST_MUL_YC: begin mul_a = py; mul_b = cx; end
      ST_MUL_HD: begin mul_a = pw; mul_b = RAD_TO_TURN_Q16; end
      default: begin end
    endcase
  end

  assign item.ready       = (state == ST_IDLE);
  assign result.valid     = res_valid;
  assign result.pos_x     = res_x;
  assign result.pos_y     = res_y;
  assign result.heading   = res_hdg;
  assign result.saturated = res_sat;

  // Control and pose state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter      <= '0;
      pose_x    <= '0;
      pose_y    <= '0;
      yaw       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Load a new result when the register is free or draining this cycle,
      // else drop the flag once the held result transfers.
      if (state == ST_DONE && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE:   iter <= '0;
        ST_ROTATE: iter <= iter + CW'(1);
        ST_POS: begin
          pose_x <= pose_x_next;
          pose_y <= pose_y_next;
          yaw    <= yaw_next;
        end
        default: begin end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        // Capture the item and seed the CORDIC from the held heading.
        vx   <= item.lin_vel_x;
        vy   <= item.lin_vel_y;
        w    <= item.ang_vel;
        dt   <= item.time_step;
        cx   <= INV_GAIN_Q30;
        cy   <= 32'sd0;
        z    <= {yaw_res, 16'd0};
        quad <= yaw_bias[15:14];
      end
      ST_ROTATE: begin
        if (!z[31]) begin
          cx <= cx - sh_x;
          cy <= cy + sh_y;
          z  <= z - atan_v;
        end else begin
          cx <= cx + sh_x;
          cy <= cy - sh_y;
          z  <= z + atan_v;
        end
      end
      ST_QUAD: begin
        // Rotate by whole quarter turns.
        unique case (quad)
          2'd0: begin end
          2'd1: begin cx <= -cy; cy <= cx;  end
          2'd2: begin cx <= -cx; cy <= -cy; end
          2'd3: begin cx <= cy;  cy <= -cx; end
          default: begin end
        endcase
      end
      ST_MUL_PX: prod <= mul_p;
      ST_MUL_PY: begin px <= prod[31:0]; prod <= mul_p; end
      ST_MUL_PW: begin py <= prod[31:0]; prod <= mul_p; end
      ST_MUL_XC: begin pw <= prod[31:0]; prod <= mul_p; end
      ST_MUL_YS: begin acc <= prod; prod <= mul_p; end
      ST_MUL_XS: begin accx <= acc - prod; prod <= mul_p; end
      ST_MUL_YC: begin acc <= prod; prod <= mul_p; end
      ST_MUL_HD: begin accy <= acc + prod; prod <= mul_p; end
      ST_POS:    clip <= ovf_x | ovf_y;
      ST_DONE: begin
        if (!res_valid || result.ready) begin
          res_x   <= 32'(pose_x);
          res_y   <= 32'(pose_y);
          res_hdg <= yaw;
          res_sat <= clip;
        end
      end
      default: begin end
    endcase
  end

endmodule
